// File: hdl/sleep_countdown_table_unit_assert.svh
// Assertion macros for the sleeper table unit.
// Each macro builds one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is held low.
`ifndef SLEEP_COUNTDOWN_TABLE_UNIT_ASSERT_SVH
`define SLEEP_COUNTDOWN_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sct assertion failed");

// Next-cycle implication.
`define SCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sct assertion failed");

`endif

// File: hdl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants
// Widths, table geometry and request formats used by the sleeper table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int THREAD_W = 8;
    localparam int DUR_W    = 24;
    localparam int TICK_W   = 16;

    localparam logic [TICK_W-1:0] TICK_RESET = 16'd100;

    // opcode field codes
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // status field codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        CMD_SLEEP = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [THREAD_W-1:0]   thread;
        logic [DUR_W-1:0]      duration;
    } cmd_t;

    // front to back handoff
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [DUR_W-1:0]    remaining;
    } entry_t;

endpackage

`default_nettype wire

// File: hdl/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front: request intake
// Accepts input requests, classifies them and holds them in a two-entry queue
// until the table engine takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [sct_pkg::THREAD_W-1:0]   thread_id,
    input  logic [sct_pkg::DUR_W-1:0]      duration,
    output sct_pkg::cmd_chan_t             cmd_chan,
    input  logic                           cmd_pop
);
    import sct_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] q_cnt_reg;
    logic [1:0] q_cnt_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    assign in_stall = (q_cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = cmd_pop && (q_cnt_reg != 2'd0);

    always_comb
    begin
        new_cmd.kind     = (opcode == OP_TICK) ? CMD_TICK : CMD_SLEEP;
        new_cmd.thread   = thread_id;
        new_cmd.duration = duration;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign cmd_chan.valid = (q_cnt_reg != 2'd0);
    assign cmd_chan.cmd   = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: hdl/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back: table engine
// Holds the sleeper table, appends sleep requests, walks the table one entry
// per cycle on a tick unless output stall holds it, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sct_pkg::TICK_W-1:0]     cfg_data,
    input  sct_pkg::cmd_chan_t             cmd_chan,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           wake_valid,
    output logic [sct_pkg::THREAD_W-1:0]   woken_thread,
    output logic                           status,
    output logic                           last
);
    import sct_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [TICK_W-1:0]    tick_amount_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     kept_reg;
    logic [CNT_W-1:0]     kept_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [THREAD_W-1:0]  pend_thread_reg;
    logic [THREAD_W-1:0]  pend_thread_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 wake_valid_reg;
    logic                 wake_valid_next;
    logic [THREAD_W-1:0]  woken_thread_reg;
    logic [THREAD_W-1:0]  woken_thread_next;
    logic                 status_reg;
    logic                 status_next;
    logic                 last_reg;
    logic                 last_next;

    entry_t               mem [TABLE_DEPTH];
    entry_t               rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 out_free;
    logic                 wakes;
    logic                 end_entry;
    logic [DUR_W-1:0]     tick_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_amount_reg <= TICK_RESET;
        end
        else if (cfg_valid)
        begin
            tick_amount_reg <= cfg_data;
        end
    end

    assign tick_ext  = DUR_W'(tick_amount_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign wakes     = (rd_data_reg.remaining <= tick_ext);
    assign end_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        kept_next         = kept_reg;
        idx_next          = idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_thread_next  = pend_thread_reg;
        out_valid_next    = out_valid_reg && out_stall;
        wake_valid_next   = wake_valid_reg;
        woken_thread_next = woken_thread_reg;
        status_next       = status_reg;
        last_next         = last_reg;
        cmd_pop           = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = idx_reg;
        wr_en             = 1'b0;
        wr_addr           = count_reg[IDX_W-1:0];
        wr_data.thread    = cmd_chan.cmd.thread;
        wr_data.remaining = cmd_chan.cmd.duration;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_chan.valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_chan.cmd.kind == CMD_SLEEP)
                    begin
                        out_valid_next    = 1'b1;
                        wake_valid_next   = 1'b0;
                        woken_thread_next = '0;
                        last_next         = 1'b1;
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = STATUS_OK;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next    = 1'b1;
                        wake_valid_next   = 1'b0;
                        woken_thread_next = '0;
                        status_next       = STATUS_OK;
                        last_next         = 1'b1;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = '0;
                        idx_next        = '0;
                        kept_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // a wake is held until the next one, so the final one can carry last
                if (!(wakes && pend_valid_reg && !out_free))
                begin
                    if (wakes)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next    = 1'b1;
                            wake_valid_next   = 1'b1;
                            woken_thread_next = pend_thread_reg;
                            status_next       = STATUS_OK;
                            last_next         = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_thread_next = rd_data_reg.thread;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = kept_reg[IDX_W-1:0];
                        wr_data.thread    = rd_data_reg.thread;
                        wr_data.remaining = rd_data_reg.remaining - tick_ext;
                        kept_next         = kept_reg + CNT_W'(1);
                    end
                    if (end_entry)
                    begin
                        count_next = wakes ? kept_reg : (kept_reg + CNT_W'(1));
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    wake_valid_next   = pend_valid_reg;
                    woken_thread_next = pend_valid_reg ? pend_thread_reg : '0;
                    status_next       = STATUS_OK;
                    last_next         = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            kept_reg         <= '0;
            idx_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_thread_reg  <= '0;
            out_valid_reg    <= 1'b0;
            wake_valid_reg   <= 1'b0;
            woken_thread_reg <= '0;
            status_reg       <= STATUS_OK;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            kept_reg         <= kept_next;
            idx_reg          <= idx_next;
            pend_valid_reg   <= pend_valid_next;
            pend_thread_reg  <= pend_thread_next;
            out_valid_reg    <= out_valid_next;
            wake_valid_reg   <= wake_valid_next;
            woken_thread_reg <= woken_thread_next;
            status_reg       <= status_next;
            last_reg         <= last_next;
        end
    end

    // table memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign wake_valid   = wake_valid_reg;
    assign woken_thread = woken_thread_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// File: hdl/sleep_countdown_table_unit.sv
// ----------------------------------------------------------------------------
// sleep_countdown_table_unit: sleeper table with countdown ticks
// Keeps up to TABLE_DEPTH sleeping threads in arrival order and wakes them
// as timer ticks count their remaining time down.
// ----------------------------------------------------------------------------
// A sleep request (opcode 0) appends a thread to the table and returns one
// result, status 1 if the table was full. A tick (opcode 1) subtracts
// tick_amount from every entry and returns one wake result per expiring
// thread in table order, last set on the final one, or a single empty result
// if nobody wakes. Requests pass through a two-entry queue into the table
// engine. A sleep request, or a tick on an empty table, is answered from the
// idle state. Any other tick starts in the idle state, then walks the stored
// entries, the table memory's single read port delivering one entry per cycle
// unless output stall holds the walk, and closes with a final result.
// The table needs no clearing after reset. tick_amount is written through the
// cfg port and should change only while the unit is idle.
`default_nettype none

module sleep_countdown_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sct_pkg::TICK_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [sct_pkg::THREAD_W-1:0]   thread_id,
    input  logic [sct_pkg::DUR_W-1:0]      duration,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           wake_valid,
    output logic [sct_pkg::THREAD_W-1:0]   woken_thread,
    output logic                           status,
    output logic                           last
);
    import sct_pkg::*;

    cmd_chan_t cmd_chan;
    logic      cmd_pop;

    sct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .thread_id (thread_id),
        .duration  (duration),
        .cmd_chan  (cmd_chan),
        .cmd_pop   (cmd_pop)
    );

    sct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd_chan     (cmd_chan),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .wake_valid   (wake_valid),
        .woken_thread (woken_thread),
        .status       (status),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: hdl/sct_checker.sv
// ----------------------------------------------------------------------------
// sct_checker: port-level checks
// Watches the result channel of the sleeper table unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sleep_countdown_table_unit_assert.svh"

module sct_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           wake_valid,
    input  logic [sct_pkg::THREAD_W-1:0]   woken_thread,
    input  logic                           status,
    input  logic                           last
);
    import sct_pkg::*;

    // stalled result holds
    `SCT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(woken_thread) && $stable(wake_valid) && $stable(last))

    // only wakes can be followed by more results of the same request
    `SCT_ASSERT_IMP(a_nowake_last, clk, rst_n, out_valid && !wake_valid, last)

    // a wake never reports a full table
    `SCT_ASSERT_IMP(a_wake_ok, clk, rst_n, out_valid && wake_valid, status == STATUS_OK)

    // a non-wake result carries no thread
    `SCT_ASSERT_IMP(a_nowake_zero, clk, rst_n, out_valid && !wake_valid, woken_thread == '0)

endmodule

bind sleep_countdown_table_unit sct_checker u_sct_checker (.*);

`default_nettype wire

// File: bench/tb_sleep_countdown_table_unit.sv
// ----------------------------------------------------------------------------
// tb_sleep_countdown_table_unit: self-checking bench for the sleeper table
// Drives sleep and tick requests with random gaps and output stall, predicts
// every wake result from a local copy of the table and checks each result in
// order. The tick amount is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module tb_sleep_countdown_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int IDLE_PERCENT = 18;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic                wake;
        logic [THREAD_W-1:0] thread;
        logic                status;
        logic                last;
    } wake_result_t;

    class wake_scoreboard;
        entry_t            slots[TABLE_DEPTH];
        int unsigned       used;
        logic [TICK_W-1:0] tick_amount;
        wake_result_t      pending_results[$];
        int                errors;

        function new();
            used        = 0;
            tick_amount = TICK_RESET;
            errors      = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Work out the results of one accepted request and update the table.
        function void note_request(input cmd_kind_t kind, input logic [THREAD_W-1:0] tid,
                                   input logic [DUR_W-1:0] dur);
            wake_result_t r;
            wake_result_t held;
            bit           have_held;
            int unsigned  kept;
            r         = '{wake: 1'b0, thread: '0, status: STATUS_OK, last: 1'b1};
            held      = r;
            have_held = 1'b0;
            kept      = 0;
            if (kind == CMD_SLEEP)
            begin
                if (used < TABLE_DEPTH)
                begin
                    slots[used] = '{thread: tid, remaining: dur};
                    used++;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
                pending_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (slots[i].remaining <= DUR_W'(tick_amount))
                    begin
                        // hold each wake back until we know whether it is the final one
                        if (have_held)
                            pending_results.push_back(held);
                        held = '{wake: 1'b1, thread: slots[i].thread, status: STATUS_OK,
                                 last: 1'b0};
                        have_held = 1'b1;
                    end
                    else
                    begin
                        slots[kept] = '{thread: slots[i].thread,
                                        remaining: slots[i].remaining - DUR_W'(tick_amount)};
                        kept++;
                    end
                end
                used = kept;
                if (have_held)
                begin
                    held.last = 1'b1;
                    pending_results.push_back(held);
                end
                else
                begin
                    pending_results.push_back(r);
                end
            end
        endfunction

        task check_result(input wake_result_t got);
            wake_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with nothing expected: wake=%0b thread=%0d",
                                 got.wake, got.thread));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.wake !== want.wake)
                    report($sformatf("wake_valid %0b, expected %0b", got.wake, want.wake));
                if (got.thread !== want.thread)
                    report($sformatf("woken_thread %0d, expected %0d",
                                     got.thread, want.thread));
                if (got.status !== want.status)
                    report($sformatf("status %0b, expected %0b", got.status, want.status));
                if (got.last !== want.last)
                    report($sformatf("last %0b, expected %0b", got.last, want.last));
            end
        endtask
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [TICK_W-1:0]   cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                opcode       = OP_SLEEP;
    logic [THREAD_W-1:0] thread_id    = '0;
    logic [DUR_W-1:0]    duration     = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                wake_valid;
    logic [THREAD_W-1:0] woken_thread;
    logic                status;
    logic                last;

    bit                  steady       = 1'b0;
    int                  idle_cycles  = 0;
    wake_scoreboard      sb;

    sleep_countdown_table_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .thread_id    (thread_id),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .wake_valid   (wake_valid),
        .woken_thread (woken_thread),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{wake: wake_valid, thread: woken_thread, status: status,
                              last: last});
    end

    // no request, result or register write for too long means the unit hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_sleep_countdown_table_unit: FAIL");
                $finish;
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_request(input cmd_kind_t kind, input logic [THREAD_W-1:0] tid,
                                input logic [DUR_W-1:0] dur);
        while (!steady && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= kind;
        thread_id <= tid;
        duration  <= dur;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(kind, tid, dur);
        @(negedge clk);
    endtask

    task automatic sleep_request(input logic [THREAD_W-1:0] tid, input logic [DUR_W-1:0] dur);
        send_request(CMD_SLEEP, tid, dur);
    endtask

    task automatic tick_request();
        send_request(CMD_TICK, THREAD_W'($urandom), DUR_W'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_tick_amount(input logic [TICK_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.tick_amount = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // tick until the predicted table is empty
    task automatic drain_table();
        while (sb.used != 0)
            tick_request();
    endtask

    // Durations mostly land a few ticks out, with exact and off-by-one boundaries.
    function automatic logic [DUR_W-1:0] pick_duration(input logic [TICK_W-1:0] t);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 5);
        if (t == 0)
            return (r < 50) ? '0 : DUR_W'($urandom_range(1, 1000));
        if (t == '1 && r < 4)
            return DUR_W'($urandom);
        if (r < 15)
            return DUR_W'(k * t);
        if (r < 30)
            return DUR_W'(k * t + 1);
        return DUR_W'($urandom_range(0, 6 * t));
    endfunction

    task automatic random_requests(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 30)
                tick_request();
            else
                sleep_request(THREAD_W'($urandom_range(0, 255)), pick_duration(sb.tick_amount));
        end
    endtask

    initial
    begin
        logic [TICK_W-1:0] tick_plan[4];
        sb = new();
        tick_plan[0] = 16'd1;
        tick_plan[1] = TICK_W'($urandom_range(2, 65534));
        tick_plan[2] = 16'd0;
        tick_plan[3] = TICK_W'($urandom_range(30000, 65534));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: default tick amount of 100
        tick_request();                 // empty table
        sleep_request(8'h00, 24'd0);    // wakes on the next tick
        sleep_request(8'hFF, 24'd100);  // equal to the tick amount
        sleep_request(8'h5A, 24'd101);  // one unit left after a tick
        tick_request();
        tick_request();
        for (int i = 0; i < TABLE_DEPTH; i++)
            sleep_request(THREAD_W'(i * 17), (i % 2 == 0) ? 24'd50 : 24'd250);
        sleep_request(8'hC3, 24'd0);    // table full
        tick_request();                 // half the table wakes, the rest compacts
        tick_request();
        drain_table();

        // largest tick amount, with the widest durations
        wait_idle();
        write_tick_amount(16'hFFFF);
        sleep_request(8'hA5, 24'hFFFFFF);
        sleep_request(8'h3C, 24'd65535);
        sleep_request(8'h96, 24'd65536);
        tick_request();
        tick_request();
        random_requests(30);
        drain_table();

        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            write_tick_amount(tick_plan[p]);
            steady = (p == 1);
            random_requests(25);
            steady = 1'b0;
            if (sb.tick_amount != 0)
                drain_table();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb_sleep_countdown_table_unit: PASS");
        else
            $display("tb_sleep_countdown_table_unit: FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_front.sv
hdl/sct_back.sv
hdl/sleep_countdown_table_unit.sv
hdl/sct_checker.sv
bench/tb_sleep_countdown_table_unit.sv
